>>> sv/sample_timestamp_tracker_core_assert.svh
// Assertion macros for the sample timestamp tracker.
// Taken in by the top level; needs nothing else.
`ifndef SAMPLE_TIMESTAMP_TRACKER_CORE_ASSERT_SVH
`define SAMPLE_TIMESTAMP_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset
`define STT_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define STT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/stt_pkg.sv
// Shared constants and types for the sample timestamp tracker.
// Used by the divider and the top level; depends on nothing.
package stt_pkg;

   // Fixed field widths
   localparam int INDEX_BITS   = 64;
   localparam int SECONDS_BITS = 64;
   localparam int COMMAND_BITS = 2;

   // Defaults for the top-level parameters
   localparam int DEFAULT_FRACTION_BITS = 32;
   localparam int DEFAULT_RATE_BITS     = 32;

   // Command codes
   localparam logic [COMMAND_BITS-1:0] CMD_SET_ANCHOR = 2'd0;
   localparam logic [COMMAND_BITS-1:0] CMD_SET_RATE   = 2'd1;
   localparam logic [COMMAND_BITS-1:0] CMD_QUERY      = 2'd2;

   // Divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> sv/stt_divider.sv
// Restoring divider for the sample timestamp tracker: one quotient bit a cycle.
// Divides {dividend, FRACTION_BITS zeros} by the rate. Depends on stt_pkg.
module stt_divider #(
   parameter int FRACTION_BITS = stt_pkg::DEFAULT_FRACTION_BITS,
   parameter int RATE_BITS     = stt_pkg::DEFAULT_RATE_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   input  logic [stt_pkg::INDEX_BITS-1:0]               dividend,
   input  logic [RATE_BITS-1:0]                         divisor,
   output stt_pkg::div_status_type                      status,
   output logic [stt_pkg::INDEX_BITS+FRACTION_BITS-1:0] quotient
);

   localparam int QUO_BITS = stt_pkg::INDEX_BITS + FRACTION_BITS;
   localparam int CNT_BITS = $clog2(QUO_BITS + 1);

   logic [RATE_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;
   logic [RATE_BITS-1:0] divisor_ff;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 done_ff, done_in;
   logic [RATE_BITS:0]   trial;
   logic [RATE_BITS:0]   diff;

   // Shared subtract-and-compare step
   assign trial = {rem_ff, quo_ff[QUO_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   // Load on start, otherwise shift one dividend bit in and one quotient bit out
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = {dividend, {FRACTION_BITS{1'b0}}};
         count_in = CNT_BITS'(QUO_BITS);
      end else if (count_ff != '0) begin
         if (!diff[RATE_BITS]) begin
            rem_in = diff[RATE_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[RATE_BITS-1:0];
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
         count_in = count_ff - CNT_BITS'(1);
         done_in  = (count_ff == CNT_BITS'(1));
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

>>> sv/sample_timestamp_tracker_core.sv
// Top level of the sample timestamp tracker: anchor and rate state, sequencer,
// output register. Depends on stt_pkg, stt_divider and the assertion header.
//
//   channel   direction  tdata (low bit up)                        tuser
//   req_      in         sample_index, anchor_seconds,             command
//                        anchor_fraction, new_rate
//   rsp_      out        time_seconds, time_fraction               time_valid
//   csr_      in         write enable and initial rate, no handshake
//
// Anchor and rate commands leave the sequencer idle. A query runs through the restoring
// divider, which yields one quotient bit a cycle, then a register for its done flag, a
// fraction-add state and the output register load; the next item is taken after that load,
// which waits while the output register still holds an untaken result.
// A query that finds no anchor, no rate or a zero rate skips the divider and goes straight
// to the output register load.
// req_tready is high only while the sequencer is idle; a finished result waits
// in the output register, and a later query holds there until it is taken.
// reset is synchronous: it clears the state, the stored rate and rsp_tvalid.
`include "sample_timestamp_tracker_core_assert.svh"

module sample_timestamp_tracker_core #(
   parameter int FRACTION_BITS = stt_pkg::DEFAULT_FRACTION_BITS,
   parameter int RATE_BITS     = stt_pkg::DEFAULT_RATE_BITS,
   parameter int REQ_BITS      = ((2 * stt_pkg::INDEX_BITS + FRACTION_BITS + RATE_BITS
                                   + 7) / 8) * 8,
   parameter int RSP_BITS      = ((stt_pkg::SECONDS_BITS + FRACTION_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request items
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sample_index, anchor_seconds, anchor_fraction, new_rate
   input  logic [REQ_BITS-1:0]              req_tdata,
   // command
   input  logic [stt_pkg::COMMAND_BITS-1:0] req_tuser,
   // Result items
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // time_seconds, time_fraction
   output logic [RSP_BITS-1:0]              rsp_tdata,
   // time_valid
   output logic                             rsp_tuser,
   // Initial rate register
   input  logic                             csr_wr_en,
   input  logic [RATE_BITS-1:0]             csr_wr_data
);

   localparam int IB       = stt_pkg::INDEX_BITS;
   localparam int SB       = stt_pkg::SECONDS_BITS;
   localparam int SEC_LO   = IB;
   localparam int FRAC_LO  = IB + SB;
   localparam int RATE_LO  = FRAC_LO + FRACTION_BITS;
   localparam int QUO_BITS = IB + FRACTION_BITS;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_FRAC = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Request fields
   logic [IB-1:0]            req_index;
   logic [SB-1:0]            req_seconds;
   logic [FRACTION_BITS-1:0] req_fraction;
   logic [RATE_BITS-1:0]     req_rate;
   logic                     req_accept;

   assign req_index    = req_tdata[IB-1:0];
   assign req_seconds  = req_tdata[SEC_LO+SB-1:SEC_LO];
   assign req_fraction = req_tdata[RATE_LO-1:FRAC_LO];
   assign req_rate     = req_tdata[RATE_LO+RATE_BITS-1:RATE_LO];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_accept   = req_tvalid && req_tready;

   // Anchor and rate state
   logic [IB-1:0]            anchor_index_ff;
   logic [SB-1:0]            anchor_whole_ff;
   logic [FRACTION_BITS-1:0] anchor_frac_ff;
   logic [RATE_BITS-1:0]     current_rate_ff;
   logic                     anchor_seen_ff;
   logic                     rate_seen_ff;
   logic                     query_ok;
   logic                     query_ok_ff;

   assign query_ok = anchor_seen_ff && rate_seen_ff && (current_rate_ff != '0);

   // Shared divider
   logic                    div_start;
   stt_pkg::div_status_type div_status;
   logic [QUO_BITS-1:0]     div_quotient;

   assign div_start = req_accept && (req_tuser == stt_pkg::CMD_QUERY) && query_ok;

   stt_divider #(
      .FRACTION_BITS (FRACTION_BITS),
      .RATE_BITS     (RATE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_index - anchor_index_ff),
      .divisor  (current_rate_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Fraction sum with its carry into the seconds
   logic [FRACTION_BITS:0] frac_sum_ff;

   // Output register
   logic                     rsp_tvalid_ff;
   logic [SB-1:0]            rsp_sec_ff;
   logic [FRACTION_BITS-1:0] rsp_frac_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_load;

   assign rsp_load = (state_ff == S_OUT) && (!rsp_tvalid_ff || rsp_tready);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_tuser == stt_pkg::CMD_QUERY)) begin
               state_in = query_ok ? S_DIV : S_OUT;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_FRAC;
            end
         end
         S_FRAC: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state: sequencer, seen flags, rate, result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         anchor_seen_ff  <= 1'b0;
         rate_seen_ff    <= 1'b0;
         current_rate_ff <= '0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && !rate_seen_ff) begin
            current_rate_ff <= csr_wr_data;
         end
         if (req_accept && (req_tuser == stt_pkg::CMD_SET_ANCHOR)) begin
            anchor_seen_ff <= 1'b1;
         end
         if (req_accept && (req_tuser == stt_pkg::CMD_SET_RATE)) begin
            rate_seen_ff    <= 1'b1;
            current_rate_ff <= req_rate;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Payload: anchor, query status, fraction sum, result
   always_ff @(posedge clock) begin
      if (req_accept && (req_tuser == stt_pkg::CMD_SET_ANCHOR)) begin
         anchor_index_ff <= req_index;
         anchor_whole_ff <= req_seconds;
         anchor_frac_ff  <= req_fraction;
      end
      if (req_accept && (req_tuser == stt_pkg::CMD_QUERY)) begin
         query_ok_ff <= query_ok;
      end
      if (state_ff == S_FRAC) begin
         frac_sum_ff <= {1'b0, div_quotient[FRACTION_BITS-1:0]} + {1'b0, anchor_frac_ff};
      end
      if (rsp_load) begin
         rsp_valid_ff <= query_ok_ff;
         if (query_ok_ff) begin
            rsp_sec_ff  <= div_quotient[QUO_BITS-1:FRACTION_BITS] + anchor_whole_ff
                           + SB'(frac_sum_ff[FRACTION_BITS]);
            rsp_frac_ff <= frac_sum_ff[FRACTION_BITS-1:0];
         end else begin
            rsp_sec_ff  <= '0;
            rsp_frac_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_frac_ff, rsp_sec_ff});
   assign rsp_tuser  = rsp_valid_ff;

   // Checks
   `STT_ASSERT_SAME(a_idle_div_quiet, clock, reset, req_tready, !div_status.busy, "divider busy while idle")
   `STT_ASSERT_SAME(a_done_in_div, clock, reset, div_status.done, state_ff == S_DIV, "divider done outside divide state")
   `STT_ASSERT_NEXT(a_query_drops_ready, clock, reset, req_accept && (req_tuser == stt_pkg::CMD_QUERY), !req_tready, "ready held after query")
   `STT_ASSERT_SAME(a_invalid_zero, clock, reset, rsp_tvalid_ff && !rsp_valid_ff, (rsp_sec_ff == '0) && (rsp_frac_ff == '0), "invalid result carries data")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for sample_timestamp_tracker_core: directed and random
// anchor, rate and query items checked against an in-bench timestamp predictor.
// Depends on stt_pkg and the core RTL only.
module tb_top;

   localparam int FRAC_W       = 32;
   localparam int RATE_W       = 32;
   localparam int REQ_W        = 192;
   localparam int RSP_W        = 96;
   localparam int QUERY_CYCLES = 64 + FRAC_W + 3;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int HOLD_CYCLES  = 800;
   localparam int PHASE_ITEMS  = 90;

   typedef logic [stt_pkg::COMMAND_BITS-1:0] command_type;
   localparam command_type CMD_UNUSED = 2'd3;

   typedef struct packed {
      command_type       command;
      logic [63:0]       sample_index;
      logic [63:0]       anchor_seconds;
      logic [FRAC_W-1:0] anchor_fraction;
      logic [RATE_W-1:0] new_rate;
   } req_item_type;

   typedef struct packed {
      logic [63:0]       seconds;
      logic [FRAC_W-1:0] fraction;
      logic              valid;
   } sample_time_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   command_type       req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tuser;
   logic              csr_wr_en = 1'b0;
   logic [RATE_W-1:0] csr_wr_data = '0;

   // Predictor state: anchor, rate and register copy
   logic [63:0]       anc_sample = '0;
   logic [63:0]       anc_secs = '0;
   logic [FRAC_W-1:0] anc_frac = '0;
   logic [RATE_W-1:0] rate_now = '0;
   logic [RATE_W-1:0] rate_reg = '0;
   logic              have_anchor = 1'b0;
   logic              have_rate = 1'b0;

   sample_time_type   pending_times[$];
   sample_time_type   want;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   logic              hold_active = 1'b0;

   sample_timestamp_tracker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL sample_timestamp_tracker_core");
         $finish;
      end
   end

   // Drive result-side ready: random stalls, forced low during a hold-off
   always @(posedge clock) begin
      rsp_tready <= !hold_active && ($urandom_range(99) >= stall_pct);
   end

   // Time of a queried sample from the current anchor and rate
   function automatic sample_time_type time_of_sample(input logic [63:0] idx);
      sample_time_type   t;
      logic [63:0]       span;
      logic [63:0]       whole;
      logic [63:0]       rem;
      logic [95:0]       scaled;
      logic [FRAC_W-1:0] frac;
      logic [FRAC_W:0]   frac_sum;
      t = '0;
      if (have_anchor && have_rate && rate_now != '0) begin
         span     = idx - anc_sample;
         whole    = span / 64'(rate_now);
         rem      = span % 64'(rate_now);
         scaled   = {rem, {FRAC_W{1'b0}}};
         frac     = FRAC_W'(scaled / 96'(rate_now));
         frac_sum = {1'b0, frac} + {1'b0, anc_frac};
         t.seconds  = whole + anc_secs + 64'(frac_sum[FRAC_W]);
         t.fraction = frac_sum[FRAC_W-1:0];
         t.valid    = 1'b1;
      end
      return t;
   endfunction

   // Compare each accepted result with the oldest expectation
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_times.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %h/%h/%b", $time,
                     rsp_tdata[63:0], rsp_tdata[95:64], rsp_tuser);
         end else begin
            want = pending_times.pop_front();
            if (rsp_tdata[63:0] !== want.seconds) begin
               mismatch_count++;
               $display("%0t: time_seconds expected %h, actual %h", $time,
                        want.seconds, rsp_tdata[63:0]);
            end
            if (rsp_tdata[95:64] !== want.fraction) begin
               mismatch_count++;
               $display("%0t: time_fraction expected %h, actual %h", $time,
                        want.fraction, rsp_tdata[95:64]);
            end
            if (rsp_tuser !== want.valid) begin
               mismatch_count++;
               $display("%0t: time_valid expected %b, actual %b", $time,
                        want.valid, rsp_tuser);
            end
         end
      end
   end

   // Offer one item, wait for acceptance, then advance the predictor
   task automatic send_item(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.command;
      req_tdata  <= {it.new_rate, it.anchor_fraction, it.anchor_seconds, it.sample_index};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      case (it.command)
         stt_pkg::CMD_SET_ANCHOR: begin
            anc_sample  = it.sample_index;
            anc_secs    = it.anchor_seconds;
            anc_frac    = it.anchor_fraction;
            have_anchor = 1'b1;
         end
         stt_pkg::CMD_SET_RATE: begin
            rate_now  = it.new_rate;
            have_rate = 1'b1;
         end
         stt_pkg::CMD_QUERY: pending_times.push_back(time_of_sample(it.sample_index));
         default: ;
      endcase
   endtask

   // Item with random content in every field
   function automatic req_item_type noise_item(input command_type cmd);
      req_item_type it;
      it.command         = cmd;
      it.sample_index    = {$urandom, $urandom};
      it.anchor_seconds  = {$urandom, $urandom};
      it.anchor_fraction = $urandom;
      it.new_rate        = $urandom;
      return it;
   endfunction

   task automatic send_anchor(input logic [63:0] idx, input logic [63:0] secs,
                              input logic [FRAC_W-1:0] frac);
      req_item_type it;
      it = noise_item(stt_pkg::CMD_SET_ANCHOR);
      it.sample_index    = idx;
      it.anchor_seconds  = secs;
      it.anchor_fraction = frac;
      send_item(it);
   endtask

   task automatic send_rate(input logic [RATE_W-1:0] rate);
      req_item_type it;
      it = noise_item(stt_pkg::CMD_SET_RATE);
      it.new_rate = rate;
      send_item(it);
   endtask

   task automatic send_query(input logic [63:0] idx);
      req_item_type it;
      it = noise_item(stt_pkg::CMD_QUERY);
      it.sample_index = idx;
      send_item(it);
   endtask

   // Drop valid, drain all results, then let a possible busy query finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_times.size() != 0) @(posedge clock);
      repeat (QUERY_CYCLES + 10) @(posedge clock);
   endtask

   // Write the initial rate register while the block is idle
   task automatic write_initial_rate(input logic [RATE_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rate_reg = value;
      if (!have_rate) rate_now = rate_reg;
   endtask

   // Mostly well-formed traffic around the current anchor, some noise
   function automatic req_item_type random_request();
      req_item_type it;
      int           pick;
      int           sel;
      pick = $urandom_range(99);
      sel  = $urandom_range(99);
      if (pick < 15) begin
         it = noise_item(stt_pkg::CMD_SET_ANCHOR);
         if (sel < 50) it.anchor_seconds = 64'($urandom_range(0, 100000));
      end else if (pick < 28) begin
         it = noise_item(stt_pkg::CMD_SET_RATE);
         if (sel < 5) it.new_rate = '0;
         else if (sel < 35) it.new_rate = $urandom_range(1, 1000);
         else if (sel < 65) it.new_rate = $urandom_range(8000, 200000);
      end else if (pick < 95) begin
         it = noise_item(stt_pkg::CMD_QUERY);
         if (sel < 60)
            it.sample_index = anc_sample + 64'($urandom_range(0, 2000000)) - 64'd1000000;
         else if (sel < 80)
            it.sample_index = anc_sample + {24'd0, 8'($urandom_range(0, 255)), $urandom};
      end else begin
         it = noise_item(CMD_UNUSED);
      end
      return it;
   endfunction

   // Not-ready answers: no anchor, rate only from the register, zero rate
   task automatic test_not_ready();
      write_initial_rate(32'd48000);
      send_query({$urandom, $urandom});
      send_anchor(64'd1000, 64'd5, 32'h8000_0000);
      send_query(64'd49000);
      send_rate('0);
      send_query(64'd49000);
      send_query(64'd1000);
   endtask

   // Extremes of index, seconds, fraction and rate; carry and wrap
   task automatic test_field_extremes();
      send_rate(32'd1);
      send_anchor('0, '0, '0);
      send_query('0);
      send_query('1);
      send_rate('1);
      send_anchor('1, '1, '1);
      send_query('1);
      send_query(64'hFFFF_FFFF_7FFF_FFFF);
      send_query('0);
      send_rate(32'd48000);
      send_anchor(64'd1000, 64'd7, 32'hFFFF_FFFF);
      send_query(64'd999);
      send_query(64'd25000);
      send_query(64'd1000);
      write_initial_rate('0);
      write_initial_rate('1);
      send_query(64'd97000);
   endtask

   // Unused command must leave the state alone and produce nothing
   task automatic test_unused_command();
      req_item_type it;
      it = noise_item(CMD_UNUSED);
      it.sample_index   = '1;
      it.anchor_seconds = '1;
      it.new_rate       = '0;
      send_item(it);
      send_item(noise_item(CMD_UNUSED));
      send_query(64'd49000);
   endtask

   // One idling phase of random traffic, opened by a fresh anchor and rate
   task automatic test_random_traffic(input int send_pct, input int rcv_pct,
                                      input logic [RATE_W-1:0] reg_value);
      req_item_type it;
      int           sent;
      write_initial_rate(reg_value);
      send_idle_pct = send_pct;
      stall_pct     = rcv_pct;
      send_anchor({$urandom, $urandom}, 64'($urandom_range(0, 100000)), $urandom);
      send_rate($urandom_range(1, 200000));
      sent = 2;
      while (sent < PHASE_ITEMS) begin
         it = random_request();
         send_item(it);
         if (it.command != CMD_UNUSED) sent++;
      end
   endtask

   // Hold the result side off while queries keep coming, so the input stalls
   task automatic test_output_backpressure();
      wait_idle();
      send_idle_pct = 0;
      stall_pct     = 0;
      fork
         begin
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end
      join_none
      send_anchor(64'd5000, 64'd100, $urandom);
      send_rate(32'd44100);
      repeat (6) send_query(64'd5000 + 64'($urandom_range(0, 1000000)));
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_not_ready();
      test_field_extremes();
      test_unused_command();
      test_random_traffic(0, 0, '0);
      test_random_traffic(47, 0, '1);
      test_output_backpressure();
      test_random_traffic(0, 47, $urandom);
      test_random_traffic(10, 10, $urandom);
      wait_idle();
      if (mismatch_count == 0 && pending_times.size() == 0) begin
         $display("PASS sample_timestamp_tracker_core");
      end else begin
         $display("FAIL sample_timestamp_tracker_core");
      end
      $finish;
   end

endmodule
